FILE: design/dbvs_pkg.sv
// ----------------------------------------------------------------------------
// dbvs_pkg
// Shared constants and types for the DEM bilinear sampler with void handling.
// ----------------------------------------------------------------------------
package dbvs_pkg;

    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_FRAC_BITS   = 12;

    // corners at or below this level are void (33 bits covers sample widths up to 33 bits)
    localparam int VOID_CMP_BITS = 33;
    localparam logic signed [VOID_CMP_BITS-1:0] VOID_LIMIT = -33'sd32000;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_NODATA_ENABLE = 1'b0,
        REG_NODATA_VALUE  = 1'b1
    } cfg_reg_t;

    // request side status flags
    typedef struct packed {
        logic outside_bounds;
        logic fetch_error;
    } in_flags_t;

    // result side status flags
    typedef struct packed {
        logic is_void;
        logic has_value;
    } out_flags_t;

endpackage

FILE: design/dem_bilinear_void_sampler_core.sv
// Throughput: one request per cycle while the m_ side keeps taking results; an
// accepted request passes five register stages with their own valid bits,
// so bubbles fill while a result waits at the output register.
// Reset (aresetn low, synchronous): pipeline emptied, nodata disabled,
// nodata value set to the most negative sample.
// ----------------------------------------------------------------------------
// dem_bilinear_void_sampler_core
// Bilinear DEM sampler with nodata/void corner handling, stream interface.
// ----------------------------------------------------------------------------
module dem_bilinear_void_sampler_core #(
    parameter int SAMPLE_BITS = dbvs_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = dbvs_pkg::DEF_FRAC_BITS,
    localparam int S_TDATA_BITS = ((4 * SAMPLE_BITS + 2 * (FRAC_BITS + 1) + 7) / 8) * 8,
    localparam int M_TDATA_BITS = ((SAMPLE_BITS + 4 + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dbvs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0]            cfg_data,
    // requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // corner_top_left, corner_top_right, corner_bottom_left,
    // corner_bottom_right, frac_x, frac_y, zero fill
    input  logic [S_TDATA_BITS-1:0]           s_tdata,
    // fetch_error, outside_bounds
    input  logic [1:0]                        s_tuser,
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // elevation, zero fill
    output logic [M_TDATA_BITS-1:0]           m_tdata,
    // has_value, is_void
    output logic [1:0]                        m_tuser
);

    localparam int S  = SAMPLE_BITS;
    localparam int FW = FRAC_BITS + 1;

    // ---------------- configuration registers ----------------
    logic                nodata_enable_reg;
    logic signed [S-1:0] nodata_value_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nodata_enable_reg <= 1'b0;
            nodata_value_reg  <= {1'b1, {(S-1){1'b0}}};
        end else if (cfg_valid) begin
            case (dbvs_pkg::cfg_reg_t'(cfg_index))
                dbvs_pkg::REG_NODATA_ENABLE: nodata_enable_reg <= cfg_data[0];
                dbvs_pkg::REG_NODATA_VALUE:  nodata_value_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- unpack ----------------
    dbvs_pkg::in_flags_t  in_flags;
    dbvs_pkg::out_flags_t out_flags;
    logic signed [S+3:0]  out_elevation;

    assign in_flags.fetch_error    = s_tuser[0];
    assign in_flags.outside_bounds = s_tuser[1];

    dbvs_pipe #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_pipe (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .nodata_enable (nodata_enable_reg),
        .nodata_value  (nodata_value_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_corner_tl  (s_tdata[0*S +: S]),
        .in_corner_tr  (s_tdata[1*S +: S]),
        .in_corner_bl  (s_tdata[2*S +: S]),
        .in_corner_br  (s_tdata[3*S +: S]),
        .in_frac_x     (s_tdata[4*S +: FW]),
        .in_frac_y     (s_tdata[4*S+FW +: FW]),
        .in_flags      (in_flags),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_elevation (out_elevation),
        .out_flags     (out_flags)
    );

    // ---------------- pack ----------------
    assign m_tdata    = M_TDATA_BITS'($unsigned(out_elevation));
    assign m_tuser[0] = out_flags.has_value;
    assign m_tuser[1] = out_flags.is_void;

endmodule

FILE: design/dbvs_pipe.sv
// ----------------------------------------------------------------------------
// dbvs_pipe
// Five-stage datapath: void detect, products, sums, weighting and nearest
// pick, final select into the output register. Per-stage valid/ready.
// ----------------------------------------------------------------------------
module dbvs_pipe #(
    parameter int SAMPLE_BITS = dbvs_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = dbvs_pkg::DEF_FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         nodata_enable,
    input  logic signed [SAMPLE_BITS-1:0] nodata_value,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_corner_tl,
    input  logic signed [SAMPLE_BITS-1:0] in_corner_tr,
    input  logic signed [SAMPLE_BITS-1:0] in_corner_bl,
    input  logic signed [SAMPLE_BITS-1:0] in_corner_br,
    input  logic [FRAC_BITS:0]           in_frac_x,
    input  logic [FRAC_BITS:0]           in_frac_y,
    input  dbvs_pkg::in_flags_t          in_flags,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [SAMPLE_BITS+3:0] out_elevation,
    output dbvs_pkg::out_flags_t         out_flags
);

    localparam int S     = SAMPLE_BITS;
    localparam int FW    = FRAC_BITS + 1;
    localparam int PW    = S + FRAC_BITS + 2;      // corner * weight, and row sums
    localparam int QW    = PW + FRAC_BITS + 2;     // row * weight, and final sum
    localparam int SQW   = 2 * FW;
    localparam int DW    = SQW + 1;
    localparam int EW    = S + 4;
    localparam int SHIFT = 2 * FRAC_BITS - 4;
    localparam int VW    = dbvs_pkg::VOID_CMP_BITS;
    localparam logic [FW-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // ---------------- handshake chain ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // ---------------- stage 1: void flags, fraction clamp ----------------
    logic signed [S-1:0] corner_in [4];
    logic [3:0]          void_next;
    logic [FW-1:0]       fx_next, fy_next;

    assign corner_in[0] = in_corner_tl;
    assign corner_in[1] = in_corner_tr;
    assign corner_in[2] = in_corner_bl;
    assign corner_in[3] = in_corner_br;

    always_comb begin
        logic signed [VW-1:0] wide;
        for (int i = 0; i < 4; i++) begin
            wide = {{(VW-S){corner_in[i][S-1]}}, corner_in[i]};
            void_next[i] = (nodata_enable && corner_in[i] == nodata_value) ||
                           (wide <= dbvs_pkg::VOID_LIMIT);
        end
    end

    // a fraction above one saturates to one
    assign fx_next = in_frac_x[FRAC_BITS] ? FRAC_ONE : in_frac_x;
    assign fy_next = in_frac_y[FRAC_BITS] ? FRAC_ONE : in_frac_y;

    logic signed [S-1:0] s1_corner_reg [4];
    logic [3:0]          s1_void_reg;
    logic [FW-1:0]       s1_fx_reg, s1_fy_reg, s1_gx_reg, s1_gy_reg;
    dbvs_pkg::in_flags_t s1_flags_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            for (int i = 0; i < 4; i++) s1_corner_reg[i] <= corner_in[i];
            s1_void_reg  <= void_next;
            s1_fx_reg    <= fx_next;
            s1_fy_reg    <= fy_next;
            s1_gx_reg    <= FRAC_ONE - fx_next;
            s1_gy_reg    <= FRAC_ONE - fy_next;
            s1_flags_reg <= in_flags;
        end
    end

    // ---------------- stage 2: weighted corners, squared fractions ----------------
    logic signed [PW-1:0] prod_next [4];

    always_comb begin
        prod_next[0] = $signed(s1_corner_reg[0]) * $signed({1'b0, s1_gx_reg});
        prod_next[1] = $signed(s1_corner_reg[1]) * $signed({1'b0, s1_fx_reg});
        prod_next[2] = $signed(s1_corner_reg[2]) * $signed({1'b0, s1_gx_reg});
        prod_next[3] = $signed(s1_corner_reg[3]) * $signed({1'b0, s1_fx_reg});
    end

    logic signed [S-1:0]  s2_corner_reg [4];
    logic signed [PW-1:0] s2_prod_reg [4];
    logic [SQW-1:0]       s2_fx2_reg, s2_fy2_reg, s2_gx2_reg, s2_gy2_reg;
    logic [FW-1:0]        s2_fy_reg, s2_gy_reg;
    logic [3:0]           s2_void_reg;
    dbvs_pkg::in_flags_t  s2_flags_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            for (int i = 0; i < 4; i++) begin
                s2_corner_reg[i] <= s1_corner_reg[i];
                s2_prod_reg[i]   <= prod_next[i];
            end
            s2_fx2_reg   <= SQW'(s1_fx_reg * s1_fx_reg);
            s2_fy2_reg   <= SQW'(s1_fy_reg * s1_fy_reg);
            s2_gx2_reg   <= SQW'(s1_gx_reg * s1_gx_reg);
            s2_gy2_reg   <= SQW'(s1_gy_reg * s1_gy_reg);
            s2_fy_reg    <= s1_fy_reg;
            s2_gy_reg    <= s1_gy_reg;
            s2_void_reg  <= s1_void_reg;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    // ---------------- stage 3: row sums, corner distances ----------------
    logic signed [S-1:0]  s3_corner_reg [4];
    logic signed [PW-1:0] s3_top_reg, s3_bot_reg;
    logic [DW-1:0]        s3_dist_reg [4];
    logic [FW-1:0]        s3_fy_reg, s3_gy_reg;
    logic [3:0]           s3_void_reg;
    dbvs_pkg::in_flags_t  s3_flags_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            for (int i = 0; i < 4; i++) s3_corner_reg[i] <= s2_corner_reg[i];
            s3_top_reg     <= s2_prod_reg[0] + s2_prod_reg[1];
            s3_bot_reg     <= s2_prod_reg[2] + s2_prod_reg[3];
            s3_dist_reg[0] <= DW'(s2_fx2_reg) + DW'(s2_fy2_reg);
            s3_dist_reg[1] <= DW'(s2_gx2_reg) + DW'(s2_fy2_reg);
            s3_dist_reg[2] <= DW'(s2_fx2_reg) + DW'(s2_gy2_reg);
            s3_dist_reg[3] <= DW'(s2_gx2_reg) + DW'(s2_gy2_reg);
            s3_fy_reg      <= s2_fy_reg;
            s3_gy_reg      <= s2_gy_reg;
            s3_void_reg    <= s2_void_reg;
            s3_flags_reg   <= s2_flags_reg;
        end
    end

    // ---------------- stage 4: vertical weighting, nearest valid corner ----------------
    logic signed [QW-1:0] wtop_next, wbot_next;
    logic signed [S-1:0]  nearest_next;

    assign wtop_next = s3_top_reg * $signed({1'b0, s3_gy_reg});
    assign wbot_next = s3_bot_reg * $signed({1'b0, s3_fy_reg});

    // strict compare keeps the lowest index on a tie
    always_comb begin
        logic          found;
        logic [DW-1:0] best;
        found        = 1'b0;
        best         = '0;
        nearest_next = s3_corner_reg[0];
        for (int i = 0; i < 4; i++) begin
            if (!s3_void_reg[i] && (!found || s3_dist_reg[i] < best)) begin
                found        = 1'b1;
                best         = s3_dist_reg[i];
                nearest_next = s3_corner_reg[i];
            end
        end
    end

    logic signed [QW-1:0] s4_wtop_reg, s4_wbot_reg;
    logic signed [S-1:0]  s4_nearest_reg;
    logic                 s4_any_void_reg, s4_all_void_reg;
    dbvs_pkg::in_flags_t  s4_flags_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            s4_wtop_reg     <= wtop_next;
            s4_wbot_reg     <= wbot_next;
            s4_nearest_reg  <= nearest_next;
            s4_any_void_reg <= |s3_void_reg;
            s4_all_void_reg <= &s3_void_reg;
            s4_flags_reg    <= s3_flags_reg;
        end
    end

    // ---------------- stage 5: result select into output register ----------------
    logic signed [QW-1:0] sum_next, shifted_next;
    logic signed [EW-1:0] elev_next;
    dbvs_pkg::out_flags_t flags_next;

    assign sum_next     = s4_wtop_reg + s4_wbot_reg;
    assign shifted_next = sum_next >>> SHIFT;   // floor toward minus infinity

    always_comb begin
        if (s4_flags_reg.outside_bounds) begin
            elev_next            = '0;
            flags_next.has_value = 1'b0;
            flags_next.is_void   = 1'b0;
        end else if (s4_flags_reg.fetch_error || s4_all_void_reg) begin
            elev_next            = '0;
            flags_next.has_value = 1'b1;
            flags_next.is_void   = 1'b1;
        end else if (!s4_any_void_reg) begin
            elev_next            = shifted_next[EW-1:0];
            flags_next.has_value = 1'b1;
            flags_next.is_void   = 1'b0;
        end else begin
            elev_next            = {s4_nearest_reg, 4'b0000};
            flags_next.has_value = 1'b1;
            flags_next.is_void   = 1'b0;
        end
    end

    logic signed [EW-1:0] s5_elev_reg;
    dbvs_pkg::out_flags_t s5_flags_reg;

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            s5_elev_reg  <= elev_next;
            s5_flags_reg <= flags_next;
        end
    end

    assign out_valid     = v5_reg;
    assign out_elevation = s5_elev_reg;
    assign out_flags     = s5_flags_reg;

endmodule

FILE: verif/dem_bilinear_void_sampler_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dem_bilinear_void_sampler_core_tb
// Drives 2x2 corner queries through the sampler and checks every elevation:
// bilinear blend, nearest valid corner, void and outside cases, under several
// nodata settings. Both stream sides idle at random; one long receiver
// hold-off backs the pipeline up into the request side.
// ----------------------------------------------------------------------------
module dem_bilinear_void_sampler_core_tb;
    import dbvs_pkg::*;

    localparam int SAMPLE_W    = DEF_SAMPLE_BITS;
    localparam int FRAC_W      = DEF_FRAC_BITS;
    localparam int ELEV_W      = SAMPLE_W + 4;
    localparam int S_BITS      = ((4 * SAMPLE_W + 2 * (FRAC_W + 1) + 7) / 8) * 8;
    localparam int M_BITS      = ((ELEV_W + 7) / 8) * 8;
    localparam longint UNITY   = longint'(1) << FRAC_W;
    localparam longint VOID_LEVEL = -32000;
    localparam int LATENCY     = 5;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int RAND_PER_SET = 245;
    localparam int NUM_DIR     = 23;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] top_left;
        logic signed [SAMPLE_W-1:0] top_right;
        logic signed [SAMPLE_W-1:0] bottom_left;
        logic signed [SAMPLE_W-1:0] bottom_right;
        logic [FRAC_W:0]            frac_x;
        logic [FRAC_W:0]            frac_y;
        logic                       fetch_error;
        logic                       outside_bounds;
    } query_t;

    typedef struct packed {
        logic                     has_value;
        logic signed [ELEV_W-1:0] elevation;
        logic                     is_void;
    } sample_t;

    // set_cfg / nodata enable / nodata value, query, typed flag, typed result
    typedef struct packed {
        logic                       set_cfg;
        logic                       nd_en;
        logic signed [SAMPLE_W-1:0] nd_val;
        query_t                     q;
        logic                       typed;
        sample_t                    want;
    } dir_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [SAMPLE_W-1:0]       cfg_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [S_BITS-1:0]         s_tdata = '0;
    logic [1:0]                s_tuser = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_BITS-1:0]         m_tdata;
    logic [1:0]                m_tuser;

    // local copy of the block's registers
    logic                       nd_enable = 1'b0;
    logic signed [SAMPLE_W-1:0] nd_value = -16'sd32768;

    sample_t sample_q [$];
    int      errors = 0;
    int      queries_sent = 0;
    int      results_seen = 0;
    int      nodata_sets = 0;
    int      idle_mode = 0;
    logic    hold_req = 1'b0;
    int      hold_cnt = 0;
    int      stall_cycles = 0;

    dir_row_t dir_table [NUM_DIR] = '{
        // reset settings: nodata disabled
        '{0, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}, 1, '{1, 0, 0}},
        '{0, 0, 0, '{32767, -5, 7, 100, 0, 0, 0, 0}, 1, '{1, 524272, 0}},
        '{0, 0, 0, '{100, 200, 300, 400, 4096, 4096, 0, 0}, 1, '{1, 6400, 0}},
        '{0, 0, 0, '{-31999, -31999, -31999, -31999, 1234, 3000, 0, 0}, 1,
          '{1, -511984, 0}},
        '{0, 0, 0, '{1, 2, 3, 1234, 8191, 8191, 0, 0}, 1, '{1, 19744, 0}},
        '{0, 0, 0, '{32767, 32767, 32767, 32767, 2048, 4095, 0, 0}, 1, '{1, 524272, 0}},
        '{0, 0, 0, '{-32000, -32000, -32000, -32000, 0, 0, 0, 0}, 1, '{1, 0, 1}},
        '{0, 0, 0, '{-32768, -32768, -32768, -32768, 4096, 0, 0, 0}, 1, '{1, 0, 1}},
        '{0, 0, 0, '{5, 6, 7, 8, 100, 200, 0, 1}, 1, '{0, 0, 0}},
        '{0, 0, 0, '{5, 6, 7, 8, 100, 200, 1, 0}, 1, '{1, 0, 1}},
        '{0, 0, 0, '{-32768, 6, 7, 8, 100, 200, 1, 1}, 1, '{0, 0, 0}},
        '{0, 0, 0, '{-9999, -9999, -9999, -9999, 777, 3333, 0, 0}, 1, '{1, -159984, 0}},
        '{0, 0, 0, '{1000, -2000, 3000, -4000, 2048, 1024, 0, 0}, 0, '{0, 0, 0}},
        '{0, 0, 0, '{-1, 0, 0, 0, 1, 0, 0, 0}, 0, '{0, 0, 0}},
        '{0, 0, 0, '{-32768, 10, 20, 30, 0, 0, 0, 0}, 0, '{0, 0, 0}},
        '{0, 0, 0, '{-32000, 10, 20, 30, 2048, 2048, 0, 0}, 0, '{0, 0, 0}},
        '{0, 0, 0, '{-32768, -32768, -32768, -4321, 0, 0, 0, 0}, 0, '{0, 0, 0}},
        '{0, 0, 0, '{11, -32768, 22, -32768, 4096, 4096, 0, 0}, 0, '{0, 0, 0}},
        // nodata at an ordinary level
        '{1, 1, -9999, '{-9999, 10, 20, 30, 0, 0, 0, 0}, 0, '{0, 0, 0}},
        '{0, 0, 0, '{-9999, -9999, -9999, -9999, 0, 0, 0, 0}, 1, '{1, 0, 1}},
        // nodata at the top of the range, then disabled again
        '{1, 1, 32767, '{32767, 32767, 32767, 32767, 1, 1, 0, 0}, 1, '{1, 0, 1}},
        '{0, 0, 0, '{32767, -31999, 0, 500, 3000, 100, 0, 0}, 0, '{0, 0, 0}},
        '{1, 0, 32767, '{32767, 32767, 32767, 32767, 0, 0, 0, 0}, 1, '{1, 524272, 0}}
    };

    dem_bilinear_void_sampler_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic sample_t predict_sample(input query_t q);
        longint  c [4];
        logic    vd [4];
        longint  fx, fy, gx, gy, top, bot, best_d;
        longint  d [4];
        int      nvoid, best;
        sample_t res;
        res = '{has_value: 1'b1, elevation: '0, is_void: 1'b0};
        if (q.outside_bounds) begin
            res.has_value = 1'b0;
            return res;
        end
        if (q.fetch_error) begin
            res.is_void = 1'b1;
            return res;
        end
        c[0] = q.top_left;
        c[1] = q.top_right;
        c[2] = q.bottom_left;
        c[3] = q.bottom_right;
        nvoid = 0;
        for (int i = 0; i < 4; i++) begin
            vd[i] = (nd_enable && c[i] == longint'(nd_value)) || c[i] <= VOID_LEVEL;
            nvoid += vd[i] ? 1 : 0;
        end
        fx = (longint'(q.frac_x) > UNITY) ? UNITY : longint'(q.frac_x);
        fy = (longint'(q.frac_y) > UNITY) ? UNITY : longint'(q.frac_y);
        gx = UNITY - fx;
        gy = UNITY - fy;
        if (nvoid == 4) begin
            res.is_void = 1'b1;
        end else if (nvoid == 0) begin
            top = c[0] * gx + c[1] * fx;
            bot = c[2] * gx + c[3] * fx;
            // arithmetic shift floors toward minus infinity
            res.elevation = ELEV_W'((top * gy + bot * fy) >>> (2 * FRAC_W - 4));
        end else begin
            d[0] = fx * fx + fy * fy;
            d[1] = gx * gx + fy * fy;
            d[2] = fx * fx + gy * gy;
            d[3] = gx * gx + gy * gy;
            best = -1;
            best_d = 0;
            for (int i = 0; i < 4; i++) begin
                if (!vd[i] && (best < 0 || d[i] < best_d)) begin
                    best = i;
                    best_d = d[i];
                end
            end
            res.elevation = ELEV_W'(c[best] * 16);
        end
        return res;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_corner();
        int unsigned roll = $urandom_range(99);
        if (roll < 76)
            return SAMPLE_W'(int'($urandom_range(64766)) - 31999);
        if (roll < 84)
            return nd_value;
        if (roll < 91)
            return SAMPLE_W'(int'($urandom_range(768)) - 32768);
        if (roll < 95)
            return SAMPLE_W'($urandom_range(65535));
        case ($urandom_range(3))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return SAMPLE_W'(-32000);
            default: return SAMPLE_W'(-31999);
        endcase
    endfunction

    function automatic logic [FRAC_W:0] random_frac();
        int unsigned roll = $urandom_range(99);
        if (roll < 75)
            return (FRAC_W + 1)'($urandom_range(4096));
        if (roll < 80)
            return '0;
        if (roll < 85)
            return (FRAC_W + 1)'(UNITY);
        if (roll < 90)
            return (FRAC_W + 1)'(UNITY / 2);
        // up to just under two: values above one saturate in the block
        return (FRAC_W + 1)'($urandom_range(8191));
    endfunction

    function automatic query_t random_query();
        query_t q;
        q.top_left       = random_corner();
        q.top_right      = random_corner();
        q.bottom_left    = random_corner();
        q.bottom_right   = random_corner();
        q.frac_x         = random_frac();
        q.frac_y         = random_frac();
        q.fetch_error    = ($urandom_range(99) < 4);
        q.outside_bounds = ($urandom_range(99) < 4);
        return q;
    endfunction

    function automatic int sender_idle_pct();
        return (idle_mode == 0) ? 7 : (idle_mode == 1) ? 51 : 0;
    endfunction

    function automatic int receiver_idle_pct();
        return (idle_mode == 0) ? 51 : (idle_mode == 1) ? 7 : 0;
    endfunction

    task automatic drive_query(input query_t q, input logic typed, input sample_t want);
        while ($urandom_range(99) < sender_idle_pct()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_BITS - 4 * SAMPLE_W - 2 * (FRAC_W + 1)){1'b0}},
                     q.frac_y, q.frac_x, q.bottom_right, q.bottom_left,
                     q.top_right, q.top_left};
        s_tuser  <= in_flags_t'{outside_bounds: q.outside_bounds,
                                fetch_error: q.fetch_error};
        do @(posedge aclk); while (!s_tready);
        sample_q.push_back(typed ? want : predict_sample(q));
        queries_sent++;
    endtask

    task automatic drain_pending();
        s_tvalid <= 1'b0;
        while (sample_q.size() != 0)
            @(posedge aclk);
    endtask

    // both registers are written back to back while the pipeline is empty
    task automatic set_nodata(input logic en, input logic [SAMPLE_W-1:0] val);
        drain_pending();
        cfg_valid <= 1'b1;
        cfg_index <= REG_NODATA_ENABLE;
        cfg_data  <= {{(SAMPLE_W - 1){1'b0}}, en};
        do @(posedge aclk); while (!cfg_ready);
        nd_enable = en;
        cfg_index <= REG_NODATA_VALUE;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        nd_value = val;
        cfg_valid <= 1'b0;
        nodata_sets++;
    endtask

    task automatic run_random_queries(input int count);
        for (int i = 0; i < count; i++)
            drive_query(random_query(), 1'b0, '0);
    endtask

    // result side: random stalls, plus one long hold-off when requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    always @(posedge aclk) begin
        sample_t    want;
        out_flags_t got_flags;
        logic signed [ELEV_W-1:0] got_elev;
        if (aresetn && m_tvalid && m_tready) begin
            got_flags = m_tuser;
            got_elev  = m_tdata[ELEV_W-1:0];
            results_seen++;
            if (sample_q.size() == 0) begin
                $error("result with no request pending: elevation %0d", got_elev);
                errors++;
            end else begin
                want = sample_q.pop_front();
                if (got_flags.has_value !== want.has_value) begin
                    $error("has_value mismatch: expected %0d, got %0d",
                           want.has_value, got_flags.has_value);
                    errors++;
                end
                if (got_elev !== want.elevation) begin
                    $error("elevation mismatch: expected %0d, got %0d",
                           want.elevation, got_elev);
                    errors++;
                end
                if (got_flags.is_void !== want.is_void) begin
                    $error("is_void mismatch: expected %0d, got %0d",
                           want.is_void, got_flags.is_void);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: %0d requests still pending", sample_q.size());
            $display("FAIL dem_bilinear_void_sampler_core");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_mode = 0;
        foreach (dir_table[i]) begin
            if (dir_table[i].set_cfg)
                set_nodata(dir_table[i].nd_en, dir_table[i].nd_val);
            drive_query(dir_table[i].q, dir_table[i].typed, dir_table[i].want);
        end

        set_nodata(1'b0, 16'h8000);
        run_random_queries(RAND_PER_SET);
        set_nodata(1'b1, SAMPLE_W'($urandom_range(65535)));
        run_random_queries(RAND_PER_SET);

        idle_mode = 1;
        set_nodata(1'b1, 16'h7fff);
        run_random_queries(RAND_PER_SET);
        set_nodata(1'b1, 16'h8000);
        run_random_queries(RAND_PER_SET);

        // no idling; receiver backs off once so the pipeline fills
        idle_mode = 2;
        set_nodata(1'b1, SAMPLE_W'(-9999));
        hold_req = 1'b1;
        run_random_queries(RAND_PER_SET);

        drain_pending();
        repeat (4 * LATENCY) @(posedge aclk);

        $display("Sent %0d queries (%0d directed) under %0d nodata settings;",
                 queries_sent, NUM_DIR, nodata_sets);
        $display("checked %0d results across three idle patterns and one long stall.",
                 results_seen);
        if (errors == 0) begin
            $display("PASS dem_bilinear_void_sampler_core");
        end else begin
            $display("FAIL dem_bilinear_void_sampler_core");
        end
        $finish;
    end

endmodule
